FILE: sv/dlt_pkg.sv
package dlt_pkg;

   localparam int DefaultEntries = 32;
   localparam int FieldWidth = 32;
   localparam int EntryWidth = 4 * FieldWidth;

   typedef enum logic [3:0] {
      OP_ADD        = 4'd0,
      OP_REMOVE     = 4'd1,
      OP_GET        = 4'd2,
      OP_ANY_CSCENE = 4'd3,
      OP_ANY_PSCENE = 4'd4,
      OP_ANY_PSLOT  = 4'd5,
      OP_LST_CSCENE = 4'd6,
      OP_LST_PSCENE = 4'd7,
      OP_LST_PSLOT  = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_DUP     = 2'd1,
      ST_MISSING = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KEY_CONSUMER = 2'd0,
      KEY_CSCENE   = 2'd1,
      KEY_PSCENE   = 2'd2,
      KEY_PSLOT    = 2'd3
   } key_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_EMIT,
      S_WAIT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load;      // capture request, clear scan index
      logic       step;      // advance scan index
      logic       rd;        // issue read of scan index
      logic       hold;      // copy the read register into the hold register
      logic       back;      // move scan index back onto the matched entry
      logic       append;    // write key to tail, bump count
      logic       shift_rd;  // read entry idx+1
      logic       shift_wr;  // write shifted entry to idx, advance
      logic       shrink;    // decrement count
      logic       out_load;  // drive output register
      status_type status;
      logic       found;
      logic       use_link;  // link fields from held entry, else from request (use_new), else zero
      logic       use_new;   // link fields from request
      logic       last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic   hit;         // read data matches key (valid cycle after rd)
      logic   scan_done;   // scan index reached count
      logic   full;
      logic   shift_done;  // idx+1 reached count
      logic   out_busy;
      op_type op;
   } stat_type;

endpackage

FILE: sv/dlt_ctrl.sv
module dlt_ctrl
   import dlt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     idle
);

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;     // a read is in flight
   logic      have_ff, have_in;     // a match is held, not yet sent

   wire is_list = stat.op inside {OP_LST_CSCENE, OP_LST_PSCENE, OP_LST_PSLOT};
   wire is_any  = stat.op inside {OP_ANY_CSCENE, OP_ANY_PSCENE, OP_ANY_PSLOT};
   wire is_cons = stat.op inside {OP_ADD, OP_REMOVE, OP_GET};
   wire hit_now = pend_ff && stat.hit;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      have_in  = have_ff;
      case (state_ff)
         S_IDLE: begin
            pend_in = 1'b0;
            have_in = 1'b0;
            if (req_fire) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (hit_now) begin
               have_in = 1'b1;
               pend_in = 1'b0;
               if (!is_list) state_in = stat.op == OP_REMOVE ? S_SHIFT : S_WAIT;
               else if (have_ff) state_in = S_EMIT;
               else pend_in = !stat.scan_done;
            end else if (stat.scan_done) begin
               pend_in  = 1'b0;
               state_in = S_WAIT;
            end else begin
               pend_in = 1'b1;
            end
         end
         S_EMIT: if (!stat.out_busy) state_in = S_SCAN;
         S_SHIFT: begin
            if (stat.shift_done && !pend_ff) state_in = S_WAIT;
            pend_in = !pend_ff && !stat.shift_done;
         end
         S_WAIT: if (!stat.out_busy) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd    = '0;
      cmd.status = ST_OK;
      idle   = state_ff == S_IDLE;
      cmd.load = state_ff == S_IDLE && req_fire;
      case (state_ff)
         S_SCAN: begin
            // a second list match waits in the read register until the first is sent
            cmd.hold = hit_now && !(is_list && have_ff);
            cmd.back = hit_now && stat.op == OP_REMOVE;
            cmd.rd   = !stat.scan_done && (!hit_now || (is_list && !have_ff));
            cmd.step = cmd.rd;
         end
         S_SHIFT: begin
            cmd.shift_rd = !pend_ff && !stat.shift_done;
            cmd.shift_wr = pend_ff;
            cmd.shrink   = stat.shift_done && !pend_ff;
         end
         S_EMIT: begin
            cmd.out_load = !stat.out_busy;
            cmd.hold     = !stat.out_busy;
            cmd.found    = 1'b1;
            cmd.use_link = 1'b1;
         end
         S_WAIT: begin
            cmd.out_load = !stat.out_busy;
            cmd.last     = 1'b1;
            if (is_cons) begin
               if (have_ff) begin
                  cmd.found    = 1'b1;
                  cmd.use_link = 1'b1;
                  cmd.status   = stat.op == OP_ADD ? ST_DUP : ST_OK;
               end else if (stat.op == OP_ADD) begin
                  cmd.status  = stat.full ? ST_FULL : ST_OK;
                  cmd.found   = !stat.full;
                  cmd.use_new = !stat.full;
                  cmd.append  = !stat.full && !stat.out_busy;
               end else begin
                  cmd.status = ST_MISSING;
               end
            end else if (is_list || is_any) begin
               cmd.found    = have_ff;
               cmd.use_link = have_ff && is_list;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         have_ff  <= have_in;
      end
   end

endmodule

FILE: sv/dlt_path.sv
module dlt_path
   import dlt_pkg::*;
#(
   parameter int TABLE_ENTRIES = DefaultEntries
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [3:0]            req_op,
   input  logic [FieldWidth-1:0] req_ps,
   input  logic [FieldWidth-1:0] req_pl,
   input  logic [FieldWidth-1:0] req_cs,
   input  logic [FieldWidth-1:0] req_cl,
   input  cmd_type               cmd,
   output stat_type              stat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [1:0]            out_status,
   output logic                  out_found,
   output logic [EntryWidth-1:0] out_link,
   output logic                  out_last
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);

   // entry layout: {cl, cs, pl, ps}
   logic [EntryWidth-1:0] mem [TABLE_ENTRIES];
   logic [EntryWidth-1:0] rd_ff, key_ff, hold_ff;
   op_type                op_ff;
   logic [CW-1:0]         cnt_ff, idx_ff;
   logic                  ov_ff;
   logic [1:0]            ost_ff;
   logic                  ofd_ff, olast_ff;
   logic [EntryWidth-1:0] olink_ff;
   logic [FieldWidth-1:0] r_ps, r_pl, r_cs, r_cl, k_ps, k_pl, k_cs, k_cl;
   logic                  hit;

   assign {r_cl, r_cs, r_pl, r_ps} = rd_ff;
   assign {k_cl, k_cs, k_pl, k_ps} = key_ff;

   always_comb begin
      case (op_ff)
         OP_ANY_CSCENE, OP_LST_CSCENE: hit = r_cs == k_cs;
         OP_ANY_PSCENE, OP_LST_PSCENE: hit = r_ps == k_ps;
         OP_ANY_PSLOT, OP_LST_PSLOT:   hit = r_ps == k_ps && r_pl == k_pl;
         OP_ADD, OP_REMOVE, OP_GET:    hit = r_cs == k_cs && r_cl == k_cl;
         default:                      hit = 1'b0;
      endcase
   end

   wire [CW-1:0] idx_nx = idx_ff + CW'(1);

   assign stat.hit        = hit && (op_ff inside {[OP_ADD:OP_LST_PSLOT]});
   assign stat.scan_done  = idx_ff == cnt_ff;
   assign stat.full       = cnt_ff == CW'(TABLE_ENTRIES);
   assign stat.shift_done = idx_nx >= cnt_ff;
   assign stat.out_busy   = ov_ff && !out_ready;
   assign stat.op         = op_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= {req_cl, req_cs, req_pl, req_ps};
         op_ff  <= op_type'(req_op);
      end
      if (cmd.rd) rd_ff <= mem[idx_ff[IW-1:0]];
      if (cmd.shift_rd) rd_ff <= mem[idx_nx[IW-1:0]];
      if (cmd.shift_wr) mem[idx_ff[IW-1:0]] <= rd_ff;
      if (cmd.append) mem[cnt_ff[IW-1:0]] <= key_ff;
      if (cmd.hold) hold_ff <= rd_ff;
      if (cmd.out_load) begin
         ost_ff   <= cmd.status;
         ofd_ff   <= cmd.found;
         olast_ff <= cmd.last;
         olink_ff <= cmd.use_link ? hold_ff : cmd.use_new ? key_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         if (cmd.load) idx_ff <= '0;
         else if (cmd.step) idx_ff <= idx_nx;
         else if (cmd.shift_wr) idx_ff <= idx_nx;
         // remove: back idx onto the matched slot before shifting
         else if (cmd.back) idx_ff <= idx_ff - CW'(1);
         if (cmd.append) cnt_ff <= cnt_ff + CW'(1);
         if (cmd.shrink) cnt_ff <= cnt_ff - CW'(1);
         if (cmd.out_load) ov_ff <= 1'b1;
         else if (out_ready) ov_ff <= 1'b0;
      end
   end

   assign out_valid  = ov_ff;
   assign out_status = ost_ff;
   assign out_found  = ofd_ff;
   assign out_link   = olink_ff;
   assign out_last   = olast_ff;

endmodule

FILE: sv/data_link_table_top.sv
// channel | direction | tdata fields (low bit up)                         | tuser | tlast
// req     | in        | op[3:0], provider_scene, provider_slot,
//         |           | consumer_scene, consumer_slot (pad to 136 bits)    | -     | -
// rsp     | out       | status[1:0], found, link_provider_scene,
//         |           | link_provider_slot, link_consumer_scene,
//         |           | link_consumer_slot (pad to 136 bits)              | -     | last
//
// One item at a time. A lookup, test or add scans the table, one entry per cycle;
// a list sends each match in its own response, tlast on the last; remove stops at
// its match, then moves each later entry down one slot, reading it then writing it.
// The single read port of the entry memory sets the pace.
// Synchronous reset empties the table at once; no clearing pass.
// A stalled rsp beat holds the scan.
module data_link_table_top
   import dlt_pkg::*;
#(
   parameter int TABLE_ENTRIES = DefaultEntries
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // op, provider_scene, provider_slot,
                                     // consumer_scene, consumer_slot
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // status, found, link_provider_scene,
                                     // link_provider_slot, link_consumer_scene,
                                     // link_consumer_slot
   output logic         rsp_tlast
);

   cmd_type               cmd;
   stat_type              stat;
   logic                  idle;
   logic [1:0]            st;
   logic                  fd;
   logic [EntryWidth-1:0] link;

   assign req_tready = idle;
   wire req_fire = req_tvalid && req_tready;

   dlt_ctrl u_ctrl (
      .clock, .reset, .req_fire, .stat, .cmd, .idle
   );

   dlt_path #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_path (
      .clock, .reset,
      .req_op (req_tdata[3:0]),
      .req_ps (req_tdata[35:4]),
      .req_pl (req_tdata[67:36]),
      .req_cs (req_tdata[99:68]),
      .req_cl (req_tdata[131:100]),
      .cmd, .stat,
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_status(st),
      .out_found (fd),
      .out_link  (link),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, link, fd, st};

endmodule
